[hw/rtl/sitda_pkg.sv]
// shared types and constants for the signed integer to decimal text converter
package sitda_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_DABBLE,
        OP_SHIFT_DIGIT
    } digit_op_t;

    typedef struct packed {
        digit_op_t op;
    } digit_cmd_t;

endpackage

[hw/rtl/signed_int_to_decimal_ascii.sv]
// top level: signed integer in, decimal ascii characters out
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    s_tdata[63:0] value (low VALUE_WIDTH bits used)
// m_*      out  m_tvalid/m_tready    m_tdata[7:0] character, m_tlast last
//
// a value is taken only while the sequencer is idle; one shift-add-3 unit builds the bcd
// magnitude at one bit a cycle, then drops each leading zero digit and finds the first digit,
// then sends one character per cycle while the output register is free, with a leading '-'
// for a negative value; reset clears the sequencer and the output valid; m_tready low holds the
// current character in the output register and stalls the sequencer when it has one to send
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] character
    output logic        m_tlast
);

    localparam int DIGITS = (VALUE_WIDTH * 302) / 1000 + 1;
    localparam int SW     = $clog2(VALUE_WIDTH + 1);
    localparam int RW     = $clog2(DIGITS + 1);

    state_t                 state_reg;
    state_t                 state_next;
    logic [SW-1:0]          step_reg;
    logic [SW-1:0]          step_next;
    logic [RW-1:0]          rem_reg;
    logic [RW-1:0]          rem_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             out_char_reg;
    logic [7:0]             out_char_next;
    logic                   out_last_reg;
    logic                   out_last_next;

    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;
    logic [3:0]             top_digit;
    logic                   out_free;
    logic                   accept;
    logic                   at_last;
    digit_cmd_t             cmd;

    assign raw      = s_tdata[VALUE_WIDTH-1:0];
    assign mag      = raw[VALUE_WIDTH-1] ? VALUE_WIDTH'(~raw + 1'b1) : raw;
    assign out_free = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign at_last  = (rem_reg == RW'(1));

    sitda_digit_unit #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIGITS      (DIGITS)
    ) u_digit_unit (
        .clk       (clk),
        .cmd       (cmd),
        .mag       (mag),
        .top_digit (top_digit)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (step_reg == SW'(1))
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (!(top_digit == 4'd0 && !at_last))
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && at_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        s_tready       = 1'b0;
        cmd.op         = OP_HOLD;
        step_next      = step_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    cmd.op    = OP_LOAD;
                    neg_next  = raw[VALUE_WIDTH-1];
                    step_next = SW'(VALUE_WIDTH);
                end
            end
            ST_CONVERT:
            begin
                cmd.op    = OP_DABBLE;
                step_next = step_reg - SW'(1);
                rem_next  = RW'(DIGITS);
            end
            ST_SKIP:
            begin
                if (top_digit == 4'd0 && !at_last)
                begin
                    cmd.op   = OP_SHIFT_DIGIT;
                    rem_next = rem_reg - RW'(1);
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.op         = OP_SHIFT_DIGIT;
                    rem_next       = rem_reg - RW'(1);
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO + {4'd0, top_digit};
                    out_last_next  = at_last;
                end
            end
            default:
            begin
                cmd.op = OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            rem_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

endmodule

[hw/rtl/sitda_digit_unit.sv]
// shared shift-add-3 unit: binary to bcd, then digit-wise shift out from the top
module sitda_digit_unit
    import sitda_pkg::*;
#(
    parameter int VALUE_WIDTH = 64,
    parameter int DIGITS      = 20
)
(
    input  logic                   clk,
    input  digit_cmd_t             cmd,
    input  logic [VALUE_WIDTH-1:0] mag,
    output logic [3:0]             top_digit
);

    logic [DIGITS*4-1:0]    bcd_reg;
    logic [DIGITS*4-1:0]    bcd_next;
    logic [VALUE_WIDTH-1:0] bin_reg;
    logic [VALUE_WIDTH-1:0] bin_next;
    logic [DIGITS*4-1:0]    bcd_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb
    begin
        bcd_next = bcd_reg;
        bin_next = bin_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                bcd_next = '0;
                bin_next = mag;
            end
            OP_DABBLE:
            begin
                bcd_next = {bcd_adj[DIGITS*4-2:0], bin_reg[VALUE_WIDTH-1]};
                bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            OP_SHIFT_DIGIT:
            begin
                bcd_next = {bcd_reg[DIGITS*4-5:0], 4'd0};
            end
            default:
            begin
                bcd_next = bcd_reg;
                bin_next = bin_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
    end

    assign top_digit = bcd_reg[DIGITS*4-1 -: 4];

endmodule
